FILE: sv/pbot_pkg.sv
// Package for the periodic box overlap test.
// Holds widths, saturation limits and the lane result type; no dependencies.
`default_nettype none
package pbot_pkg;
  localparam int COORD_WIDTH  = 32;
  localparam int PERIOD_WIDTH = 16;
  localparam int CELL_WIDTH   = 31;
  localparam int NUM_WIDTH    = COORD_WIDTH + 1;
  localparam int EXT_WIDTH    = NUM_WIDTH + 1;
  localparam int NUM_AXES     = 3;
  localparam int NUM_DIVS     = 5;
  localparam int DIV_LATENCY  = COORD_WIDTH + 2;
  localparam int PIPE_DEPTH   = DIV_LATENCY + 2;
  localparam int IDX_WIDTH    = 2;

  localparam logic [IDX_WIDTH-1:0] REG_CELL_X = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_CELL_Y = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_CELL_Z = 2'd2;

  localparam logic [CELL_WIDTH-1:0] CELL_RESET = CELL_WIDTH'(65536);

  localparam logic signed [EXT_WIDTH-1:0] PER_MAX = EXT_WIDTH'(2**(PERIOD_WIDTH-1) - 1);
  localparam logic signed [EXT_WIDTH-1:0] PER_MIN = -PER_MAX - EXT_WIDTH'(1);

  typedef struct packed {
    logic                           err;
    logic                           ovl;
    logic signed [PERIOD_WIDTH-1:0] per;
  } lane_res_t;
endpackage
`default_nettype wire

FILE: sv/pbot_div.sv
// Pipelined signed floor divider, one quotient bit per stage.
// Depends on pbot_pkg for widths.
`default_nettype none
module pbot_div
  import pbot_pkg::*;
(
  input  wire                         clk_i,
  input  wire  signed [NUM_WIDTH-1:0] num_i,
  input  wire         [CELL_WIDTH-1:0] den_i,
  output logic signed [NUM_WIDTH-1:0] quo_o,
  output logic        [CELL_WIDTH-1:0] rem_o
);
  logic [COORD_WIDTH-1:0] u_q   [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] quo_q [COORD_WIDTH+1];
  logic [CELL_WIDTH-1:0]  rem_q [COORD_WIDTH+1];
  logic                   neg_q [COORD_WIDTH+1];

  always_ff @(posedge clk_i) begin
    neg_q[0] <= num_i[NUM_WIDTH-1];
    u_q[0]   <= num_i[NUM_WIDTH-1] ? ~num_i[COORD_WIDTH-1:0] : num_i[COORD_WIDTH-1:0];
    quo_q[0] <= '0;
    rem_q[0] <= '0;
  end

  for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_stage
    logic [CELL_WIDTH:0] trial;
    logic [CELL_WIDTH:0] diff;
    logic                take;
    always_comb begin
      trial = {rem_q[k], u_q[k][COORD_WIDTH-1-k]};
      diff  = trial - {1'b0, den_i};
      take  = trial >= {1'b0, den_i};
    end
    always_ff @(posedge clk_i) begin
      neg_q[k+1] <= neg_q[k];
      u_q[k+1]   <= u_q[k];
      quo_q[k+1] <= {quo_q[k][COORD_WIDTH-2:0], take};
      rem_q[k+1] <= take ? diff[CELL_WIDTH-1:0] : trial[CELL_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (neg_q[COORD_WIDTH]) begin
      quo_o <= ~{1'b0, quo_q[COORD_WIDTH]};
      rem_o <= den_i - CELL_WIDTH'(1) - rem_q[COORD_WIDTH];
    end else begin
      quo_o <= {1'b0, quo_q[COORD_WIDTH]};
      rem_o <= rem_q[COORD_WIDTH];
    end
  end
endmodule
`default_nettype wire

FILE: sv/pbot_lane.sv
// One axis lane: five floor dividers and the origin, span and overlap decision.
// Depends on pbot_pkg and pbot_div.
`default_nettype none
module pbot_lane
  import pbot_pkg::*;
(
  input  wire                           clk_i,
  input  wire  signed [COORD_WIDTH-1:0] a_min_i,
  input  wire  signed [COORD_WIDTH-1:0] a_max_i,
  input  wire  signed [COORD_WIDTH-1:0] b_min_i,
  input  wire  signed [COORD_WIDTH-1:0] b_max_i,
  input  wire         [CELL_WIDTH-1:0]  den_i,
  output lane_res_t                     res_o
);
  logic signed [NUM_WIDTH-1:0]  num [NUM_DIVS];
  logic signed [NUM_WIDTH-1:0]  quo [NUM_DIVS];
  logic        [CELL_WIDTH-1:0] rem [NUM_DIVS];

  logic signed [NUM_WIDTH-1:0] amn, amx, bmn, bmx;
  assign amn = NUM_WIDTH'(a_min_i);
  assign amx = NUM_WIDTH'(a_max_i);
  assign bmn = NUM_WIDTH'(b_min_i);
  assign bmx = NUM_WIDTH'(b_max_i);

  assign num[0] = bmn - amn;
  assign num[1] = amx - amn;
  assign num[2] = bmx - amn;
  assign num[3] = amx - bmn;
  assign num[4] = bmx - bmn;

  for (genvar i = 0; i < NUM_DIVS; i++) begin : g_div
    pbot_div u_div (
      .clk_i (clk_i),
      .num_i (num[i]),
      .den_i (den_i),
      .quo_o (quo[i]),
      .rem_o (rem[i])
    );
  end

  logic                         nz;
  logic        [CELL_WIDTH-1:0] rab;
  logic                         org_b;
  logic signed [EXT_WIDTH-1:0]  negq;
  logic signed [EXT_WIDTH-1:0]  pamn_b;
  logic signed [EXT_WIDTH-1:0]  per;
  lane_res_t                    res_d;

  always_comb begin
    nz     = rem[0] != '0;
    rab    = nz ? den_i - rem[0] : '0;
    org_b  = nz && (rab < rem[0]);
    negq   = -EXT_WIDTH'(quo[0]);
    pamn_b = negq - EXT_WIDTH'(nz);
    per    = org_b ? pamn_b : negq;
    if (org_b) begin
      res_d.err = (pamn_b != EXT_WIDTH'(quo[3])) || (quo[4] != '0);
      res_d.ovl = rab <= rem[4];
    end else begin
      res_d.err = (quo[1] != '0) || (quo[0] != quo[2]);
      res_d.ovl = rem[1] >= rem[0];
    end
    if (per > PER_MAX) begin
      res_d.per = PERIOD_WIDTH'(PER_MAX);
    end else if (per < PER_MIN) begin
      res_d.per = PERIOD_WIDTH'(PER_MIN);
    end else begin
      res_d.per = PERIOD_WIDTH'(per);
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end
endmodule
`default_nettype wire

FILE: sv/periodic_box_overlap_test.sv
// Top level of the periodic box overlap test: cell size registers, three axis
// lanes and the merging stage. Depends on pbot_pkg and pbot_lane.
//
// One transaction is taken every cycle that start_i is high; busy_o stays low.
// Each result appears on done_o after the input register, the bit-per-stage floor
// dividers and the result register of each lane, and the merging output register.
// Results cannot be held off by the receiver. Write cell sizes only when no
// transaction is in flight; a zero cell size acts as one.
`default_nettype none
module periodic_box_overlap_test
  import pbot_pkg::*;
(
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  output logic                             busy_o,
  output logic                             done_o,
  input  wire                              cfg_we_i,
  input  wire         [IDX_WIDTH-1:0]      cfg_idx_i,
  input  wire         [CELL_WIDTH-1:0]     cfg_data_i,
  input  wire  signed [COORD_WIDTH-1:0]    a_min_x_i,
  input  wire  signed [COORD_WIDTH-1:0]    a_max_x_i,
  input  wire  signed [COORD_WIDTH-1:0]    a_min_y_i,
  input  wire  signed [COORD_WIDTH-1:0]    a_max_y_i,
  input  wire  signed [COORD_WIDTH-1:0]    a_min_z_i,
  input  wire  signed [COORD_WIDTH-1:0]    a_max_z_i,
  input  wire  signed [COORD_WIDTH-1:0]    b_min_x_i,
  input  wire  signed [COORD_WIDTH-1:0]    b_max_x_i,
  input  wire  signed [COORD_WIDTH-1:0]    b_min_y_i,
  input  wire  signed [COORD_WIDTH-1:0]    b_max_y_i,
  input  wire  signed [COORD_WIDTH-1:0]    b_min_z_i,
  input  wire  signed [COORD_WIDTH-1:0]    b_max_z_i,
  output logic                             overlap_o,
  output logic signed [PERIOD_WIDTH-1:0]   period_x_o,
  output logic signed [PERIOD_WIDTH-1:0]   period_y_o,
  output logic signed [PERIOD_WIDTH-1:0]   period_z_o,
  output logic                             span_error_o
);
  logic [CELL_WIDTH-1:0] cell_q [NUM_AXES];
  logic [CELL_WIDTH-1:0] den    [NUM_AXES];
  logic [PIPE_DEPTH-1:0] vld_q;
  lane_res_t             res    [NUM_AXES];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q[0] <= CELL_RESET;
      cell_q[1] <= CELL_RESET;
      cell_q[2] <= CELL_RESET;
      vld_q     <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], start_i};
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CELL_X: cell_q[0] <= cfg_data_i;
          REG_CELL_Y: cell_q[1] <= cfg_data_i;
          REG_CELL_Z: cell_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_den
    assign den[i] = (cell_q[i] == '0) ? CELL_WIDTH'(1) : cell_q[i];
  end

  pbot_lane u_lane_x (
    .clk_i (clk_i), .a_min_i (a_min_x_i), .a_max_i (a_max_x_i),
    .b_min_i (b_min_x_i), .b_max_i (b_max_x_i), .den_i (den[0]), .res_o (res[0])
  );
  pbot_lane u_lane_y (
    .clk_i (clk_i), .a_min_i (a_min_y_i), .a_max_i (a_max_y_i),
    .b_min_i (b_min_y_i), .b_max_i (b_max_y_i), .den_i (den[1]), .res_o (res[1])
  );
  pbot_lane u_lane_z (
    .clk_i (clk_i), .a_min_i (a_min_z_i), .a_max_i (a_max_z_i),
    .b_min_i (b_min_z_i), .b_max_i (b_max_z_i), .den_i (den[2]), .res_o (res[2])
  );

  logic                           ovl_d, err_d;
  logic signed [PERIOD_WIDTH-1:0] px_d, py_d, pz_d;

  always_comb begin
    ovl_d = 1'b0;
    err_d = 1'b0;
    px_d  = '0;
    py_d  = '0;
    pz_d  = '0;
    priority if (res[0].err) begin
      err_d = 1'b1;
    end else if (!res[0].ovl) begin
      px_d = res[0].per;
    end else if (res[1].err) begin
      err_d = 1'b1;
      px_d  = res[0].per;
    end else if (!res[1].ovl) begin
      px_d = res[0].per;
      py_d = res[1].per;
    end else if (res[2].err) begin
      err_d = 1'b1;
      px_d  = res[0].per;
      py_d  = res[1].per;
    end else begin
      ovl_d = res[2].ovl;
      px_d  = res[0].per;
      py_d  = res[1].per;
      pz_d  = res[2].per;
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_o    <= ovl_d;
    span_error_o <= err_d;
    period_x_o   <= px_d;
    period_y_o   <= py_d;
    period_z_o   <= pz_d;
  end

  assign done_o = vld_q[PIPE_DEPTH-1];
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for periodic_box_overlap_test: drives box pairs and cell
// sizes and checks each result against a per-axis minimum-image predictor.
// Depends on pbot_pkg and the periodic_box_overlap_test RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbot_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PERIOD_WIDTH-1:0] per_t;

  typedef struct {
    coord_t amn[3];
    coord_t amx[3];
    coord_t bmn[3];
    coord_t bmx[3];
  } box_pair_t;

  typedef struct {
    logic ovl;
    per_t per[3];
    logic err;
  } overlap_res_t;

  class overlap_scoreboard;
    overlap_res_t pending[$];
    longint cell_len[3];
    int errors;
    int checked;
    int overlaps;
    int spans;

    function new();
      cell_len[0] = 65536;
      cell_len[1] = 65536;
      cell_len[2] = 65536;
      errors = 0;
      checked = 0;
      overlaps = 0;
      spans = 0;
    endfunction

    function void set_cell(int idx, logic [CELL_WIDTH-1:0] v);
      if (idx < 3) cell_len[idx] = v;
    endfunction

    function void fdivmod(longint n, longint d, output longint q, output longint r);
      q = n / d;
      r = n % d;
      if (r < 0) begin
        r += d;
        q -= 1;
      end
    endfunction

    function void note_pair(box_pair_t p);
      overlap_res_t e;
      longint d, amn, amx, bmn, bmx, q, rab, rba, o;
      longint pan, pax, pbn, pbx, wan, wax, wbn, wbx, pd;
      e.ovl = 1'b1;
      e.err = 1'b0;
      for (int k = 0; k < 3; k++) e.per[k] = '0;
      for (int k = 0; k < 3; k++) begin
        d = (cell_len[k] == 0) ? 1 : cell_len[k];
        amn = p.amn[k];
        amx = p.amx[k];
        bmn = p.bmn[k];
        bmx = p.bmx[k];
        fdivmod(amn - bmn, d, q, rab);
        fdivmod(bmn - amn, d, q, rba);
        o = (rab < rba) ? bmn : amn;
        fdivmod(amn - o, d, pan, wan);
        fdivmod(amx - o, d, pax, wax);
        fdivmod(bmn - o, d, pbn, wbn);
        fdivmod(bmx - o, d, pbx, wbx);
        if (pan != pax || pbn != pbx) begin
          e.err = 1'b1;
          e.ovl = 1'b0;
          break;
        end
        pd = pan - pbn;
        if (pd > 32767) pd = 32767;
        if (pd < -32768) pd = -32768;
        e.per[k] = per_t'(pd);
        if (!(wan <= wbx && wax >= wbn)) begin
          e.ovl = 1'b0;
          break;
        end
      end
      pending = {pending, e};
    endfunction

    function void check_result(logic ovl, per_t px, per_t py, per_t pz, logic err);
      overlap_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result ovl=%0b", $time, ovl);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      overlaps += e.ovl;
      spans += e.err;
      if (ovl !== e.ovl) begin
        $display("%0t: overlap exp %0b got %0b", $time, e.ovl, ovl);
        errors++;
      end
      if (px !== e.per[0]) begin
        $display("%0t: period_x exp %0d got %0d", $time, e.per[0], px);
        errors++;
      end
      if (py !== e.per[1]) begin
        $display("%0t: period_y exp %0d got %0d", $time, e.per[1], py);
        errors++;
      end
      if (pz !== e.per[2]) begin
        $display("%0t: period_z exp %0d got %0d", $time, e.per[2], pz);
        errors++;
      end
      if (err !== e.err) begin
        $display("%0t: span_error exp %0b got %0b", $time, e.err, err);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_idx_i = '0;
  logic [CELL_WIDTH-1:0] cfg_data_i = '0;
  coord_t amn_i[3] = '{default: '0};
  coord_t amx_i[3] = '{default: '0};
  coord_t bmn_i[3] = '{default: '0};
  coord_t bmx_i[3] = '{default: '0};
  logic busy_o, done_o, overlap_o, span_error_o;
  per_t period_x_o, period_y_o, period_z_o;

  overlap_scoreboard sb = new();
  longint cycles = 0;
  int sent = 0;
  bit idle_ok = 1'b1;

  periodic_box_overlap_test DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .a_min_x_i(amn_i[0]), .a_max_x_i(amx_i[0]), .a_min_y_i(amn_i[1]),
    .a_max_y_i(amx_i[1]), .a_min_z_i(amn_i[2]), .a_max_z_i(amx_i[2]),
    .b_min_x_i(bmn_i[0]), .b_max_x_i(bmx_i[0]), .b_min_y_i(bmn_i[1]),
    .b_max_y_i(bmx_i[1]), .b_min_z_i(bmn_i[2]), .b_max_z_i(bmx_i[2]),
    .overlap_o, .period_x_o, .period_y_o, .period_z_o, .span_error_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o)
      sb.check_result(overlap_o, period_x_o, period_y_o, period_z_o, span_error_o);
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("periodic_box_overlap_test regression: fail");
      $finish;
    end
  end

  // drop the write enable after the last write of a group
  task automatic write_cell(logic [IDX_WIDTH-1:0] idx, logic [CELL_WIDTH-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_cell(idx, v);
  endtask

  // hold until every result is back, then let the pipe drain
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic send_pair(box_pair_t p);
    while (idle_ok && $urandom_range(99) < 20) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      amn_i[k] <= p.amn[k];
      amx_i[k] <= p.amx[k];
      bmn_i[k] <= p.bmn[k];
      bmx_i[k] <= p.bmx[k];
    end
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_pair(p);
    sent++;
  endtask

  task automatic stop_sending();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord(int mode, coord_t base, longint c);
    case (mode)
      0: return coord_t'($urandom);
      1: return base + coord_t'($urandom_range(0, (c > 1000000) ? 1000000 : c));
      default: return base + coord_t'(longint'($urandom_range(0, 6)) * c / 4
                        - coord_t'($urandom_range(0, 3)));
    endcase
  endfunction

  // mostly well-formed boxes near each other, some raw noise
  function automatic box_pair_t rand_pair();
    box_pair_t p;
    int mode;
    longint c;
    coord_t base;
    mode = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2);
    for (int k = 0; k < 3; k++) begin
      c = (sb.cell_len[k] == 0) ? 1 : sb.cell_len[k];
      base = coord_t'($urandom);
      p.amn[k] = rand_coord(mode, base, c);
      p.amx[k] = rand_coord(mode, p.amn[k], c / 2);
      p.bmn[k] = rand_coord(mode, base + coord_t'(longint'($urandom_range(0, 8)) * c),
                            c);
      p.bmx[k] = rand_coord(mode, p.bmn[k], c / 2);
      if ($urandom_range(19) == 0) p.amx[k] = p.amn[k] - 1;
    end
    return p;
  endfunction

  function automatic box_pair_t uniform_pair(coord_t lo, coord_t hi, coord_t blo, coord_t bhi);
    box_pair_t p;
    for (int k = 0; k < 3; k++) begin
      p.amn[k] = lo;
      p.amx[k] = hi;
      p.bmn[k] = blo;
      p.bmx[k] = bhi;
    end
    return p;
  endfunction

  logic [CELL_WIDTH-1:0] cell_sets[6][3] = '{
    '{31'd65536, 31'd65536, 31'd65536},
    '{31'd1, 31'd0, 31'h7fffffff},
    '{31'h7fffffff, 31'd3, 31'd1},
    '{31'd1000, 31'd65536, 31'd7},
    '{31'd0, 31'h7fffffff, 31'd200000},
    '{31'd12345, 31'd131072, 31'd65537}
  };

  initial begin
    box_pair_t p;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_ok = 1'b0;
    send_pair(uniform_pair(32'sd0, 32'sd1000, 32'sd500, 32'sd2000));
    send_pair(uniform_pair(32'sd0, 32'sd100, 32'sd40000, 32'sd50000));
    send_pair(uniform_pair(32'sd0, 32'sd70000, 32'sd0, 32'sd10));
    send_pair(uniform_pair(32'sd5000, 32'sd100, 32'sd0, 32'sd10));
    send_pair(uniform_pair(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    send_pair(uniform_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
    send_pair(uniform_pair(32'sh80000000, 32'sh7fffffff, 32'sd0, 32'sd0));
    send_pair(uniform_pair(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
    send_pair(uniform_pair(32'sd65536 * 100, 32'sd65536 * 100 + 5, 32'sd3, 32'sd9));
    p = uniform_pair(32'sd0, 32'sd10, 32'sd5, 32'sd20);
    p.bmn[1] = 32'sd60000;
    p.bmx[1] = 32'sd60010;
    send_pair(p);
    p = uniform_pair(32'sd0, 32'sd10, 32'sd5, 32'sd20);
    p.amx[1] = 32'sd200000;
    send_pair(p);
    stop_sending();
    drain();
    write_cell(REG_CELL_X, 31'd1);
    write_cell(REG_CELL_Y, 31'd0);
    write_cell(REG_CELL_Z, 31'h7fffffff);
    cfg_we_i <= 1'b0;
    send_pair(uniform_pair(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    send_pair(uniform_pair(32'sd3, 32'sd3, 32'sd3, 32'sd3));
    send_pair(uniform_pair(32'sh80000000, 32'sh7fffffff, 32'sd0, 32'sd0));
    stop_sending();
    drain();
    for (int s = 0; s < 6; s++) begin
      write_cell(REG_CELL_X, cell_sets[s][0]);
      write_cell(REG_CELL_Y, cell_sets[s][1]);
      write_cell(REG_CELL_Z, cell_sets[s][2]);
      cfg_we_i <= 1'b0;
      idle_ok = (s != 2);
      for (int n = 0; n < 85; n++) send_pair(rand_pair());
      stop_sending();
      drain();
    end
    $display("covered %0d box pairs over 8 cell size sets: %0d overlaps, %0d span errors",
             sb.checked, sb.overlaps, sb.spans);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("periodic_box_overlap_test regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("periodic_box_overlap_test regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
